// File: hw/rtl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// No dependencies; imported by the controller, the datapath and the top level.
package rau_pkg;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // product slots of the shared multiplier
    localparam logic [1:0] SLOT_P = 2'd0;
    localparam logic [1:0] SLOT_Q = 2'd1;
    localparam logic [1:0] SLOT_D = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       sum;
        logic       gcd_step;
        logic       g_latch;
        logic       div_step;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic gcd_done;
        logic out_busy;
    } t_stat;

endpackage

// File: hw/rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: joins controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
//  channel  | valid    | stall    | payload
//  request  | i_valid  | o_stall  | i_mode, i_left_num, i_left_den, i_right_num, i_right_den
//  result   | o_valid  | i_stall  | o_result_num, o_result_den, o_status
//
// One request at a time: accept, three multiply steps, capture, sum, binary GCD of
// up to about 2*WORD_BITS steps, WORD_BITS divider steps, then the result write;
// the run time is set mostly by the GCD loop and the divider lanes.
// Zero denominator requests and overflow in the products or the sum skip the GCD and divider.
// Reset is synchronous, active low; no clearing pass.
// A held result stalls only the final write; the next request is taken meanwhile.
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_left_num,
    input  logic signed [31:0] i_left_den,
    input  logic signed [31:0] i_right_num,
    input  logic signed [31:0] i_right_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]        o_result_den,
    output logic [1:0]         o_status
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_busy  (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_left_num   (i_left_num),
        .i_left_den   (i_left_den),
        .i_right_num  (i_right_num),
        .i_right_den  (i_right_den),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result_num (o_result_num),
        .o_result_den (o_result_den),
        .o_status     (o_status)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_num == '0 && o_result_den == '0)
        else $error("error result carries data");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_result_den != '0)
        else $error("ok result with zero denominator");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting a request");
`endif

endmodule

// File: hw/rtl/rau_ctrl.sv
// Sequencer of the rational arithmetic unit: steps the datapath through
// multiply, sum, GCD and division phases. Depends on rau_pkg.
module rau_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_busy,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_CAP2 = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_GFIN = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = SLOT_P;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = SLOT_Q;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SLOT_P;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = SLOT_D;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SLOT_Q;
                n_state       = S_CAP2;
            end
            S_CAP2: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SLOT_D;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_GCD;
            end
            S_GCD: begin
                // skip reduction once an error is flagged
                if (i_stat.err) begin
                    n_state = S_FIN;
                end else if (i_stat.gcd_done) begin
                    n_state = S_GFIN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_GFIN: begin
                o_cmd.g_latch = 1'b1;
                n_cnt         = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> !i_stat.out_busy)
        else $error("result written while output is held");
    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.g_latch |=> o_cmd.div_step && r_cnt == '0)
        else $error("division did not start after gcd");
`endif

endmodule

// File: hw/rtl/rau_dp.sv
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, binary GCD, two restoring divider lanes, output register.
// Depends on rau_pkg; driven by rau_ctrl.
module rau_dp #(
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rau_pkg::t_cmd      i_cmd,
    output rau_pkg::t_stat     o_stat,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_left_num,
    input  logic signed [31:0] i_left_den,
    input  logic signed [31:0] i_right_num,
    input  logic signed [31:0] i_right_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]        o_result_den,
    output logic [1:0]         o_status
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int KW = $clog2(W + 1);

    logic [1:0]          r_mode;
    logic signed [W-1:0] r_a, r_b, r_c, r_d;
    logic signed [W-1:0] r_p, r_q, r_den;
    logic [1:0]          r_err;
    logic signed [2*W-1:0] r_prod;
    logic [W-1:0]        r_u, r_v, r_nmag, r_dmag, r_g;
    logic [KW-1:0]       r_k;
    logic                r_nsign, r_dsign;
    logic [W-1:0]        r_nq, r_dq;
    logic [W:0]          r_nr, r_dr;
    logic                r_out_valid;
    logic signed [31:0]  r_onum;
    logic [30:0]         r_oden;
    logic [1:0]          r_ost;

    // one restoring division step: shift in the next dividend bit
    function automatic logic [2*W:0] div_step(input logic [W:0] rem,
                                              input logic [W-1:0] quo,
                                              input logic [W-1:0] dsr);
        logic [W:0] t;
        logic [W:0] dx;
        begin
            t  = {rem[W-1:0], quo[W-1]};
            dx = {1'b0, dsr};
            if (t >= dx) begin
                div_step = {t - dx, quo[W-2:0], 1'b1};
            end else begin
                div_step = {t, quo[W-2:0], 1'b0};
            end
        end
    endfunction

    logic signed [W-1:0] a_in, b_in, c_in, d_in;
    logic                zero_in;
    assign a_in    = i_left_num[W-1:0];
    assign b_in    = i_left_den[W-1:0];
    assign c_in    = i_right_num[W-1:0];
    assign d_in    = i_right_den[W-1:0];
    assign zero_in = (b_in == '0) || (d_in == '0) || (i_mode == MODE_DIV && c_in == '0);

    logic signed [W-1:0] mx, my;
    always_comb begin
        case (i_cmd.mul_sel)
            SLOT_P:  begin mx = r_a; my = (r_mode == MODE_MUL) ? r_c : r_d; end
            SLOT_Q:  begin mx = r_c; my = r_b; end
            default: begin mx = r_b; my = (r_mode == MODE_DIV) ? r_c : r_d; end
        endcase
    end

    logic prod_fits;
    assign prod_fits = (&r_prod[2*W-1:W-1]) || (~|r_prod[2*W-1:W-1]);

    logic signed [W:0] s;
    always_comb begin
        case (r_mode)
            MODE_ADD: s = r_p + r_q;
            MODE_SUB: s = r_p - r_q;
            default:  s = r_p;
        endcase
    end

    logic gcd_done;
    assign gcd_done = (r_u == '0) || (r_v == '0);

    logic [2*W:0] nstep, dstep;
    assign nstep = div_step(r_nr, r_nq, r_g);
    assign dstep = div_step(r_dr, r_dq, r_g);

    logic               neg, fin_ovf;
    logic signed [W-1:0] fin_num;
    assign neg     = (r_nsign ^ r_dsign) && (r_nq != '0);
    assign fin_num = neg ? -r_nq : r_nq;
    assign fin_ovf = (!neg && r_nq[W-1]) || r_dq[W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_a    <= a_in;
            r_b    <= b_in;
            r_c    <= c_in;
            r_d    <= d_in;
            r_err  <= zero_in ? ST_ZERO : ST_OK;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mx * my;
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                SLOT_P:  r_p   <= r_prod[W-1:0];
                SLOT_Q:  r_q   <= r_prod[W-1:0];
                default: r_den <= r_prod[W-1:0];
            endcase
            // the cross term only counts in add and subtract
            if (!prod_fits && r_err == ST_OK &&
                (i_cmd.cap_sel != SLOT_Q || r_mode == MODE_ADD || r_mode == MODE_SUB)) begin
                r_err <= ST_OVF;
            end
        end
        if (i_cmd.sum) begin
            if (s[W] != s[W-1] && r_err == ST_OK) begin
                r_err <= ST_OVF;
            end
            r_nsign <= s[W-1];
            r_dsign <= r_den[W-1];
            r_nmag  <= s[W-1] ? W'(-s) : s[W-1:0];
            r_u     <= s[W-1] ? W'(-s) : s[W-1:0];
            r_dmag  <= r_den[W-1] ? -r_den : r_den;
            r_v     <= r_den[W-1] ? -r_den : r_den;
            r_k     <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end
        if (i_cmd.g_latch) begin
            r_g  <= (r_u | r_v) << r_k;
            r_nq <= r_nmag;
            r_dq <= r_dmag;
            r_nr <= '0;
            r_dr <= '0;
        end
        if (i_cmd.div_step) begin
            r_nr <= nstep[2*W:W];
            r_nq <= nstep[W-1:0];
            r_dr <= dstep[2*W:W];
            r_dq <= dstep[W-1:0];
        end
        if (i_cmd.fin) begin
            if (r_err != ST_OK) begin
                r_onum <= '0;
                r_oden <= '0;
                r_ost  <= r_err;
            end else if (fin_ovf) begin
                r_onum <= '0;
                r_oden <= '0;
                r_ost  <= ST_OVF;
            end else begin
                r_onum <= 32'(fin_num);
                r_oden <= 31'(r_dq);
                r_ost  <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.err      = (r_err != ST_OK);
    assign o_stat.gcd_done = gcd_done;
    assign o_stat.out_busy = r_out_valid && i_stall;

    assign o_valid      = r_out_valid;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_status     = r_ost;

endmodule

// File: sim/rational_arith_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the rational arithmetic unit: directed and random requests,
// results checked against an in-bench predictor. Depends on rau_pkg and the RTL.
module rational_arith_unit_tb;
    import rau_pkg::*;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
    } t_fraction_res;

    class fraction_scoreboard;
        t_fraction_res pending[$];
        int            fails;

        function automatic bit out_of_word(longint v);
            return v > 64'sd2147483647 || v < -64'sd2147483648;
        endfunction

        function automatic longint unsigned gcd64(longint unsigned p, longint unsigned q);
            longint unsigned r;
            while (q != 0) begin
                r = p % q;
                p = q;
                q = r;
            end
            return p;
        endfunction

        // predict one request and queue its result
        function automatic void note_request(logic [1:0] mode, logic signed [31:0] a,
                                             logic signed [31:0] b, logic signed [31:0] c,
                                             logic signed [31:0] d);
            t_fraction_res   e;
            longint          num, den, p, q, la, lb, lc, ld;
            longint unsigned g;
            la = a; lb = b; lc = c; ld = d;
            num = 0; den = 1;
            e = '0;
            e.status = ST_OK;
            if (b == 0 || d == 0 || (mode == MODE_DIV && c == 0)) begin
                e.status = ST_ZERO;
            end else begin
                case (mode)
                    MODE_ADD, MODE_SUB: begin
                        p = la * ld;
                        q = lc * lb;
                        den = lb * ld;
                        if (out_of_word(p) || out_of_word(q) || out_of_word(den)) begin
                            e.status = ST_OVF;
                        end else begin
                            num = (mode == MODE_ADD) ? p + q : p - q;
                            if (out_of_word(num)) e.status = ST_OVF;
                        end
                    end
                    MODE_MUL: begin
                        num = la * lc;
                        den = lb * ld;
                        if (out_of_word(num) || out_of_word(den)) e.status = ST_OVF;
                    end
                    default: begin
                        num = la * ld;
                        den = lb * lc;
                        if (out_of_word(num) || out_of_word(den)) e.status = ST_OVF;
                    end
                endcase
                if (e.status == ST_OK) begin
                    g = gcd64(num < 0 ? -num : num, den < 0 ? -den : den);
                    num = num / longint'(g);
                    den = den / longint'(g);
                    if (den < 0) begin
                        num = -num;
                        den = -den;
                    end
                    if (out_of_word(num) || out_of_word(den)) begin
                        e.status = ST_OVF;
                    end else begin
                        e.num = num[31:0];
                        e.den = den[30:0];
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function automatic void check_result(logic signed [31:0] num, logic [30:0] den,
                                             logic [1:0] status);
            t_fraction_res e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: %0d/%0d st %0d", num, den, status);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                fails++;
            end
            if (num !== e.num) begin
                $error("result_num: expected %0d, got %0d", e.num, num);
                fails++;
            end
            if (den !== e.den) begin
                $error("result_den: expected %0d, got %0d", e.den, den);
                fails++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         req_mode = MODE_ADD;
    logic signed [31:0] req_a = '0, req_b = '0, req_c = '0, req_d = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         res_status;

    fraction_scoreboard sb = new();
    longint cycles = 0;
    bit     hold_off = 1'b0;

    always #2 clk = ~clk;

    rational_arith_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_mode(req_mode), .i_left_num(req_a), .i_left_den(req_b),
        .i_right_num(req_c), .i_right_den(req_d),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_result_num(res_num), .o_result_den(res_den), .o_status(res_status)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req_mode, req_a, req_b, req_c, req_d);
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_num, res_den, res_status);
        if (cycles > 3000000) begin
            $display("rational_arith_unit_tb: FAIL");
            $finish;
        end
    end

    // offer one request and hold it until taken; drop valid only for a non-zero gap
    task automatic send_request(logic [1:0] m, logic [31:0] a, logic [31:0] b,
                                logic [31:0] c, logic [31:0] d);
        int gap;
        gap = (hold_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_mode <= m;
        req_a <= a; req_b <= b; req_c <= c; req_d <= d;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'sh80000000 :
                      ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh0);
            2, 3: return $signed($urandom_range(0, 30)) - 15;
            4, 5: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 131070)) - 65535;
        endcase
    endfunction

    // receiver: random wait per result, one long hold-off while requests pile up
    initial begin
        int n;
        int w;
        n = 0;
        wait (rst_n);
        @(negedge clk);
        while (1) begin
            n++;
            w = $urandom_range(0, 7);
            if (n == 40) begin
                hold_off = 1'b1;
                w = 400;
            end
            if (w != 0) begin
                res_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            hold_off = 1'b0;
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
            @(negedge clk);
        end
    end

    initial begin
        logic [31:0] mx, mn;
        int          waited;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: each operation, zero divisors, extremes, overflow, normalisation
        send_request(MODE_ADD, 1, 2, 1, 3);
        send_request(MODE_SUB, 1, 2, 1, 2);
        send_request(MODE_MUL, -3, 4, 8, -9);
        send_request(MODE_DIV, 5, 6, -10, 3);
        send_request(MODE_ADD, 1, 0, 1, 1);
        send_request(MODE_SUB, 1, 1, 1, 0);
        send_request(MODE_DIV, 1, 1, 0, 1);
        send_request(MODE_MUL, 0, 1, 0, 1);
        send_request(MODE_MUL, mn, 1, 1, 1);
        send_request(MODE_MUL, mn, -1, 1, 1);
        send_request(MODE_DIV, mn, 1, -1, 1);
        send_request(MODE_MUL, mx, mx, 1, 1);
        send_request(MODE_ADD, mx, 1, mx, 1);
        send_request(MODE_SUB, mn, 1, 1, 1);
        send_request(MODE_ADD, mx, 1, mn, 1);
        send_request(MODE_MUL, 65536, 1, 32768, 1);
        send_request(MODE_MUL, 65536, 1, 65536, 1);
        send_request(MODE_ADD, 0, -5, 0, 7);
        send_request(MODE_DIV, mx, mn, mx, mn);
        send_request(MODE_MUL, 6, -4, -2, 3);
        send_request(MODE_SUB, -1, mx, 1, mx);
        send_request(MODE_DIV, mn, mn, mn, mn);
        for (int i = 0; i < 2000; i++)
            send_request(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        waited = 0;
        while (waited < 200) begin
            @(posedge clk);
            waited++;
        end
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("rational_arith_unit_tb: PASS");
        else
            $display("rational_arith_unit_tb: FAIL");
        $finish;
    end
endmodule
